// ----- hdl/prcf_pkg.sv -----
// Package for the pitch/roll complementary filter.
// Holds the shared widths, register codes, sequencer states and the CORDIC step table.
// No dependencies.
package prcf_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int TABLE_FRAC  = 24;
    localparam int TABLE_LEN   = 24;
    localparam int GUARD_BITS  = 16;
    localparam int WEIGHT_FRAC = 16;

    localparam int ANGLE_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int MAG_LIM_W  = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    localparam int N_ITER = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS : TABLE_LEN;
    localparam int ITER_W = $clog2(TABLE_LEN);

    // CORDIC datapath: scaled samples plus headroom for the fold and gain growth
    localparam int XY_W  = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int Z_W   = TABLE_FRAC + 11;
    localparam int RSH   = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int ACC_W = ANGLE_FRAC_BITS + 11;
    localparam int MAG_W = SAMPLE_BITS + 2;

    // shared multiplier
    localparam int MUL_A_W = ANGLE_W + 2;
    localparam int MUL_B_W = WEIGHT_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 1;

    localparam logic [GAIN_W-1:0]    GYRO_GAIN_RST   = GAIN_W'(10);
    localparam logic [WEIGHT_W-1:0]  ACCEL_WEIGHT_RST = WEIGHT_W'(1311);
    localparam logic [MAG_LIM_W-1:0] MAG_LOW_RST     = MAG_LIM_W'(8192);
    localparam logic [MAG_LIM_W-1:0] MAG_HIGH_RST    = MAG_LIM_W'(32768);

    localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(longint'(180) << TABLE_FRAC);
    localparam logic signed [Z_W-1:0] Z_ROUND     = Z_W'((longint'(1) << RSH) >> 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_GAIN,
        REG_ACCEL_WEIGHT,
        REG_MAG_LOW,
        REG_MAG_HIGH
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GYRO_MUL,
        ST_GYRO_ADD,
        ST_CHECK,
        ST_CORDIC_INIT,
        ST_CORDIC_ITER,
        ST_ROUND,
        ST_BLEND_MUL,
        ST_BLEND_ADD,
        ST_DONE
    } state_t;

    // atan(2^-i) in degrees, Q24
    function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            ITER_W'(0):  v = Z_W'(754974720);
            ITER_W'(1):  v = Z_W'(445687602);
            ITER_W'(2):  v = Z_W'(235489088);
            ITER_W'(3):  v = Z_W'(119537938);
            ITER_W'(4):  v = Z_W'(60000934);
            ITER_W'(5):  v = Z_W'(30029717);
            ITER_W'(6):  v = Z_W'(15018523);
            ITER_W'(7):  v = Z_W'(7509720);
            ITER_W'(8):  v = Z_W'(3754917);
            ITER_W'(9):  v = Z_W'(1877466);
            ITER_W'(10): v = Z_W'(938734);
            ITER_W'(11): v = Z_W'(469367);
            ITER_W'(12): v = Z_W'(234684);
            ITER_W'(13): v = Z_W'(117342);
            ITER_W'(14): v = Z_W'(58671);
            ITER_W'(15): v = Z_W'(29335);
            ITER_W'(16): v = Z_W'(14668);
            ITER_W'(17): v = Z_W'(7334);
            ITER_W'(18): v = Z_W'(3667);
            ITER_W'(19): v = Z_W'(1833);
            ITER_W'(20): v = Z_W'(917);
            ITER_W'(21): v = Z_W'(458);
            ITER_W'(22): v = Z_W'(229);
            ITER_W'(23): v = Z_W'(115);
            default:     v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/prcf_if.sv -----
// Item channels of the pitch/roll complementary filter: IMU sample in, angle result out.
// Depends on prcf_pkg.
interface prcf_sample_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [prcf_pkg::SAMPLE_BITS-1:0]   accel_x;
    logic signed [prcf_pkg::SAMPLE_BITS-1:0]   accel_y;
    logic signed [prcf_pkg::SAMPLE_BITS-1:0]   accel_z;
    logic signed [prcf_pkg::SAMPLE_BITS-1:0]   gyro_x;
    logic signed [prcf_pkg::SAMPLE_BITS-1:0]   gyro_y;

    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, output ready);
endinterface

interface prcf_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [prcf_pkg::ANGLE_W-1:0]   pitch_out;
    logic signed [prcf_pkg::ANGLE_W-1:0]   roll_out;
    logic                                  accel_applied;

    modport source (output valid, pitch_out, roll_out, accel_applied, input ready);
    modport sink   (input valid, pitch_out, roll_out, accel_applied, output ready);
endinterface

// ----- hdl/pitch_roll_complementary_filter_core.sv -----
// Pitch/roll complementary filter: top level with sequencer, shared multiplier and CORDIC.
// Depends on prcf_pkg and the channel interfaces in prcf_if.sv.
//
// Usage:
//   sample : sink of IMU items (accel x/y/z, gyro x/y), valid/ready handshake.
//   result : source of one item per sample (pitch, roll, correction flag).
//   cfg_we/cfg_index/cfg_data : register writes, taken on any edge with cfg_we high;
//   write only while no item is in flight.
// Sequencing:
//   no correction  : result valid and sample.ready rise at the same edge.
//   with correction: two atan2 runs of 16 CORDIC steps each on one shift/add
//   datapath, one step per cycle, plus a multiply and an add per angle on the
//   shared multiplier and adder.
//   An atan2 of zero by zero skips its CORDIC run.
//   One item is worked at a time; sample.ready is high only while idle.
// The result sits in an output register, so the next item is taken while a result
// waits; if the receiver stalls for a whole item, the finished item holds in the
// sequencer until the output register frees.
// Reset clears both angles to zero, loads the register defaults and empties the
// output register.
module pitch_roll_complementary_filter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [prcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    prcf_sample_if.sink                       sample,
    prcf_result_if.source                     result
);

    localparam int AW = prcf_pkg::ANGLE_W;
    localparam int SW = prcf_pkg::SAMPLE_BITS;

    // config
    logic [prcf_pkg::GAIN_W-1:0]    gain_reg;
    logic [prcf_pkg::WEIGHT_W-1:0]  weight_reg;
    logic [prcf_pkg::MAG_LIM_W-1:0] mag_low_reg;
    logic [prcf_pkg::MAG_LIM_W-1:0] mag_high_reg;

    // control
    prcf_pkg::state_t                state_reg, state_next;
    logic [prcf_pkg::ITER_W-1:0]     iter_reg, iter_next;
    logic                            roll_sel_reg, roll_sel_next;
    logic                            applied_reg, applied_next;
    logic signed [AW-1:0]            pitch_reg, pitch_next;
    logic signed [AW-1:0]            roll_reg, roll_next;
    logic                            res_valid_reg, res_valid_next;

    // datapath payload
    logic signed [SW-1:0]                   ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic signed [prcf_pkg::XY_W-1:0]       x_reg, x_next, y_reg, y_next;
    logic signed [prcf_pkg::Z_W-1:0]        z_reg, z_next;
    logic signed [prcf_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic signed [prcf_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic signed [AW-1:0]                   res_pitch_reg, res_roll_reg;
    logic                                   res_applied_reg;

    logic                                   take;
    logic                                   load_res;
    logic signed [AW-1:0]                   angle_sel;
    logic signed [prcf_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [prcf_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [prcf_pkg::SUM_W-1:0]      addend;
    logic signed [prcf_pkg::SUM_W-1:0]      sum;
    logic signed [AW-1:0]                   sum_sat;
    logic [prcf_pkg::MAG_W-1:0]             mag;
    logic                                   mag_ok;
    logic signed [SW-1:0]                   cy_in;
    logic signed [prcf_pkg::XY_W-1:0]       cy_scaled, cx_scaled;
    logic signed [prcf_pkg::XY_W-1:0]       x_sh, y_sh;
    logic signed [prcf_pkg::Z_W-1:0]        z_rounded;

    function automatic logic [SW:0] abs_ext(input logic signed [SW-1:0] v);
        logic signed [SW:0] e;
        e = (SW+1)'(v);
        return e[SW] ? (SW+1)'(-e) : (SW+1)'(e);
    endfunction

    assign sample.ready         = (state_reg == prcf_pkg::ST_IDLE);
    assign take                 = sample.valid && sample.ready;
    assign result.valid         = res_valid_reg;
    assign result.pitch_out     = res_pitch_reg;
    assign result.roll_out      = res_roll_reg;
    assign result.accel_applied = res_applied_reg;

    assign angle_sel = roll_sel_reg ? roll_reg : pitch_reg;

    // shared multiplier: gyro increment or blend step
    always_comb
    begin
        if (state_reg == prcf_pkg::ST_GYRO_MUL)
        begin
            mul_a = roll_sel_reg ? -prcf_pkg::MUL_A_W'(gy_reg) : prcf_pkg::MUL_A_W'(gx_reg);
            mul_b = prcf_pkg::MUL_B_W'({1'b0, gain_reg});
        end
        else
        begin
            mul_a = prcf_pkg::MUL_A_W'(acc_reg) - prcf_pkg::MUL_A_W'(angle_sel);
            mul_b = prcf_pkg::MUL_B_W'({1'b0, weight_reg});
        end
        prod_next = mul_a * mul_b;
    end

    // shared adder with saturation to the angle width
    always_comb
    begin
        if (state_reg == prcf_pkg::ST_BLEND_ADD)
            addend = prcf_pkg::SUM_W'(prod_reg >>> prcf_pkg::WEIGHT_FRAC);
        else
            addend = prcf_pkg::SUM_W'(prod_reg);
        sum = prcf_pkg::SUM_W'(angle_sel) + addend;
        if (sum[prcf_pkg::SUM_W-1:AW-1] == '0 || sum[prcf_pkg::SUM_W-1:AW-1] == '1)
            sum_sat = sum[AW-1:0];
        else if (sum[prcf_pkg::SUM_W-1])
            sum_sat = {1'b1, {(AW-1){1'b0}}};
        else
            sum_sat = {1'b0, {(AW-1){1'b1}}};
    end

    assign mag = prcf_pkg::MAG_W'(abs_ext(ax_reg)) + prcf_pkg::MAG_W'(abs_ext(ay_reg))
               + prcf_pkg::MAG_W'(abs_ext(az_reg));
    assign mag_ok = (mag > prcf_pkg::MAG_W'(mag_low_reg)) && (mag < prcf_pkg::MAG_W'(mag_high_reg));

    // CORDIC operands
    assign cy_in     = roll_sel_reg ? ax_reg : ay_reg;
    assign cy_scaled = prcf_pkg::XY_W'(cy_in) <<< prcf_pkg::GUARD_BITS;
    assign cx_scaled = prcf_pkg::XY_W'(az_reg) <<< prcf_pkg::GUARD_BITS;
    assign x_sh      = x_reg >>> iter_reg;
    assign y_sh      = y_reg >>> iter_reg;
    assign z_rounded = (z_reg + prcf_pkg::Z_ROUND) >>> prcf_pkg::RSH;

    assign load_res = (state_reg == prcf_pkg::ST_DONE) && (!res_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        roll_sel_next  = roll_sel_reg;
        applied_next   = applied_reg;
        pitch_next     = pitch_reg;
        roll_next      = roll_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        res_valid_next = res_valid_reg;
        if (load_res)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            prcf_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    roll_sel_next = 1'b0;
                    state_next    = prcf_pkg::ST_GYRO_MUL;
                end
            end
            prcf_pkg::ST_GYRO_MUL:
                state_next = prcf_pkg::ST_GYRO_ADD;
            prcf_pkg::ST_GYRO_ADD:
            begin
                if (roll_sel_reg)
                begin
                    roll_next     = sum_sat;
                    roll_sel_next = 1'b0;
                    state_next    = prcf_pkg::ST_CHECK;
                end
                else
                begin
                    pitch_next    = sum_sat;
                    roll_sel_next = 1'b1;
                    state_next    = prcf_pkg::ST_GYRO_MUL;
                end
            end
            prcf_pkg::ST_CHECK:
            begin
                applied_next = mag_ok;
                state_next   = mag_ok ? prcf_pkg::ST_CORDIC_INIT : prcf_pkg::ST_DONE;
            end
            prcf_pkg::ST_CORDIC_INIT:
            begin
                iter_next = '0;
                if (cy_in == '0 && az_reg == '0)
                begin
                    // atan2(0,0) taken as zero
                    acc_next   = '0;
                    state_next = prcf_pkg::ST_BLEND_MUL;
                end
                else
                begin
                    if (az_reg < 0)
                    begin
                        // fold into the right half-plane, start from +/-180
                        x_next = -cx_scaled;
                        y_next = -cy_scaled;
                        z_next = (cy_in >= 0) ? prcf_pkg::Z_HALF_TURN : -prcf_pkg::Z_HALF_TURN;
                    end
                    else
                    begin
                        x_next = cx_scaled;
                        y_next = cy_scaled;
                        z_next = '0;
                    end
                    state_next = prcf_pkg::ST_CORDIC_ITER;
                end
            end
            prcf_pkg::ST_CORDIC_ITER:
            begin
                if (!y_reg[prcf_pkg::XY_W-1])
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + prcf_pkg::atan_step(iter_reg);
                end
                else
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - prcf_pkg::atan_step(iter_reg);
                end
                if (iter_reg == prcf_pkg::ITER_W'(prcf_pkg::N_ITER - 1))
                    state_next = prcf_pkg::ST_ROUND;
                else
                    iter_next = iter_reg + prcf_pkg::ITER_W'(1);
            end
            prcf_pkg::ST_ROUND:
            begin
                acc_next   = z_rounded[prcf_pkg::ACC_W-1:0];
                state_next = prcf_pkg::ST_BLEND_MUL;
            end
            prcf_pkg::ST_BLEND_MUL:
                state_next = prcf_pkg::ST_BLEND_ADD;
            prcf_pkg::ST_BLEND_ADD:
            begin
                if (roll_sel_reg)
                begin
                    roll_next  = sum_sat;
                    state_next = prcf_pkg::ST_DONE;
                end
                else
                begin
                    pitch_next    = sum_sat;
                    roll_sel_next = 1'b1;
                    state_next    = prcf_pkg::ST_CORDIC_INIT;
                end
            end
            prcf_pkg::ST_DONE:
            begin
                if (load_res)
                    state_next = prcf_pkg::ST_IDLE;
            end
            default:
                state_next = prcf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prcf_pkg::ST_IDLE;
            iter_reg      <= '0;
            roll_sel_reg  <= 1'b0;
            applied_reg   <= 1'b0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            roll_sel_reg  <= roll_sel_next;
            applied_reg   <= applied_next;
            pitch_reg     <= pitch_next;
            roll_reg      <= roll_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= prcf_pkg::GYRO_GAIN_RST;
            weight_reg   <= prcf_pkg::ACCEL_WEIGHT_RST;
            mag_low_reg  <= prcf_pkg::MAG_LOW_RST;
            mag_high_reg <= prcf_pkg::MAG_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (prcf_pkg::cfg_reg_t'(cfg_index))
                prcf_pkg::REG_GYRO_GAIN:    gain_reg     <= cfg_data[prcf_pkg::GAIN_W-1:0];
                prcf_pkg::REG_ACCEL_WEIGHT: weight_reg   <= cfg_data[prcf_pkg::WEIGHT_W-1:0];
                prcf_pkg::REG_MAG_LOW:      mag_low_reg  <= cfg_data[prcf_pkg::MAG_LIM_W-1:0];
                prcf_pkg::REG_MAG_HIGH:     mag_high_reg <= cfg_data[prcf_pkg::MAG_LIM_W-1:0];
                default:                    gain_reg     <= gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ax_reg <= sample.accel_x;
            ay_reg <= sample.accel_y;
            az_reg <= sample.accel_z;
            gx_reg <= sample.gyro_x;
            gy_reg <= sample.gyro_y;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (load_res)
        begin
            res_pitch_reg   <= pitch_reg;
            res_roll_reg    <= roll_reg;
            res_applied_reg <= applied_reg;
        end
    end

    // one item in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !sample.ready)
        else $error("sample taken while an item is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == prcf_pkg::ST_CORDIC_ITER |-> iter_reg < prcf_pkg::ITER_W'(prcf_pkg::N_ITER))
        else $error("CORDIC step count overran");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == prcf_pkg::ST_DONE)
        else $error("result raised outside the finishing state");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.accel_applied |-> mag_low_reg < mag_high_reg)
        else $error("correction flagged with an empty magnitude window");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> $stable(result.pitch_out) && $stable(result.roll_out))
        else $error("waiting result changed");

endmodule

// ----- tb/sv/prcf_attitude_checker.sv -----
// Checker for the pitch/roll complementary filter: watches the sample, result and register
// channels, predicts each result item and compares it field by field.
// Depends on prcf_pkg and the channel interfaces in prcf_if.sv.
module prcf_attitude_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [prcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prcf_pkg::CFG_DATA_W-1:0]  cfg_data,
    prcf_sample_if                           sample,
    prcf_result_if                           result,
    output int                               mismatches,
    output int                               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import prcf_pkg::*;

    localparam longint ANGLE_MAX   = 64'sd2147483647;
    localparam longint ANGLE_MIN   = -64'sd2147483648;
    localparam longint HALF_TURN   = longint'(180) << TABLE_FRAC;
    localparam int     ROUND_SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int     STEPS       = (CORDIC_ITERATIONS < TABLE_LEN) ? CORDIC_ITERATIONS
                                                                     : TABLE_LEN;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic                      applied;
    } attitude_t;

    // atan(2^-i) in Q24 degrees
    longint atan_q24 [0:23] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic [GAIN_W-1:0]         gain_q;
    logic [WEIGHT_W-1:0]       weight_q;
    logic [MAG_LIM_W-1:0]      mag_low_q;
    logic [MAG_LIM_W-1:0]      mag_high_q;
    logic signed [ANGLE_W-1:0] pitch_q;
    logic signed [ANGLE_W-1:0] roll_q;
    attitude_t                 attitude_due[$];
    int                        results_seen;

    function automatic logic signed [ANGLE_W-1:0] clamp_angle(input longint v);
        if (v > ANGLE_MAX)
            return ANGLE_MAX[ANGLE_W-1:0];
        if (v < ANGLE_MIN)
            return ANGLE_MIN[ANGLE_W-1:0];
        return v[ANGLE_W-1:0];
    endfunction

    // atan2(num, den) in degrees, rounded half up to the angle format
    function automatic longint gravity_angle(input longint num, input longint den);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     i;
        if (num == 0 && den == 0)
            return 0;
        x = den * 65536;
        y = num * 65536;
        z = 0;
        // fold the left half-plane onto the right one
        if (x < 0)
        begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q24[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q24[i];
            end
        end
        return (z + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] pull_toward(
        input logic signed [ANGLE_W-1:0] a,
        input longint                    target
    );
        longint d;
        d = (target - longint'(a)) * longint'(weight_q);
        return clamp_angle(longint'(a) + (d >>> WEIGHT_FRAC));
    endfunction

    function automatic attitude_t advance_attitude(
        input longint ax, input longint ay, input longint az,
        input longint gx, input longint gy
    );
        longint    mag;
        attitude_t r;
        pitch_q = clamp_angle(longint'(pitch_q) + gx * longint'(gain_q));
        roll_q  = clamp_angle(longint'(roll_q) - gy * longint'(gain_q));
        mag = (ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) + (az < 0 ? -az : az);
        r.applied = (mag > longint'(mag_low_q)) && (mag < longint'(mag_high_q));
        if (r.applied)
        begin
            pitch_q = pull_toward(pitch_q, gravity_angle(ay, az));
            roll_q  = pull_toward(roll_q, gravity_angle(ax, az));
        end
        r.pitch = pitch_q;
        r.roll  = roll_q;
        return r;
    endfunction

    task automatic report(input string note);
        $display("checker: %s", note);
        mismatches = mismatches + 1;
    endtask

    task automatic check_result();
        attitude_t want;
        if (attitude_due.size() == 0)
        begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
            return;
        end
        want = attitude_due.pop_front();
        if (result.pitch_out !== want.pitch)
            report($sformatf("pitch_out at result %0d: got %0d, expected %0d",
                             results_seen, result.pitch_out, want.pitch));
        if (result.roll_out !== want.roll)
            report($sformatf("roll_out at result %0d: got %0d, expected %0d",
                             results_seen, result.roll_out, want.roll));
        if (result.accel_applied !== want.applied)
            report($sformatf("accel_applied at result %0d: got %b, expected %b",
                             results_seen, result.accel_applied, want.applied));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_q       = GYRO_GAIN_RST;
            weight_q     = ACCEL_WEIGHT_RST;
            mag_low_q    = MAG_LOW_RST;
            mag_high_q   = MAG_HIGH_RST;
            pitch_q      = '0;
            roll_q       = '0;
            results_seen = 0;
            mismatches   = 0;
            attitude_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GYRO_GAIN:    gain_q     = cfg_data[GAIN_W-1:0];
                    REG_ACCEL_WEIGHT: weight_q   = cfg_data[WEIGHT_W-1:0];
                    REG_MAG_LOW:      mag_low_q  = cfg_data[MAG_LIM_W-1:0];
                    REG_MAG_HIGH:     mag_high_q = cfg_data[MAG_LIM_W-1:0];
                    default:          ;
                endcase
            end
            // a result leaving at this edge always belongs to an earlier sample
            if (result.valid && result.ready)
            begin
                check_result();
                results_seen++;
            end
            if (sample.valid && sample.ready)
                attitude_due.push_back(advance_attitude(
                    longint'(sample.accel_x), longint'(sample.accel_y),
                    longint'(sample.accel_z), longint'(sample.gyro_x),
                    longint'(sample.gyro_y)));
            outstanding <= attitude_due.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the complementary filter testbench: clock, reset, sample and register stimulus,
// result back-pressure, watchdog and verdict.
// Depends on prcf_pkg, prcf_if.sv, the filter core and prcf_attitude_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prcf_pkg::*;

    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 2000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;
    bit                    feed_steady;
    bit                    drain_steady;
    int                    lim_low;
    int                    lim_high;

    prcf_sample_if sample_ch();
    prcf_result_if result_ch();

    pitch_roll_complementary_filter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    prcf_attitude_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_span(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [15:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return 16'sh8000;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sh7fff;
        endcase
    endfunction

    task automatic send_sample(
        input logic signed [15:0] ax, input logic signed [15:0] ay,
        input logic signed [15:0] az, input logic signed [15:0] gx,
        input logic signed [15:0] gy
    );
        int gap;
        gap = idle_span(feed_steady);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= ax;
        sample_ch.accel_y <= ay;
        sample_ch.accel_z <= az;
        sample_ch.gyro_x  <= gx;
        sample_ch.gyro_y  <= gy;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
    endtask

    task automatic send_random();
        int pick;
        int span;
        int a;
        int b;
        int c;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            // gravity-like vector; its target magnitude is drawn inside the current window when that window is usable
            if (lim_high - lim_low >= 2 && lim_high <= 98304)
                span = $urandom_range(lim_low + 1, lim_high - 1);
            else
                span = $urandom_range(2000, 40000);
            a = $urandom_range(0, span);
            b = $urandom_range(0, span - a);
            c = span - a - b;
            if (a > 32767) a = 32767;
            if (b > 32767) b = 32767;
            if (c > 32767) c = 32767;
            if ($urandom_range(0, 1)) a = -a;
            if ($urandom_range(0, 1)) b = -b;
            if ($urandom_range(0, 1)) c = -c;
            case ($urandom_range(0, 2))
                0:
                begin
                    ax = 16'(a); ay = 16'(b); az = 16'(c);
                end
                1:
                begin
                    ax = 16'(b); ay = 16'(c); az = 16'(a);
                end
                default:
                begin
                    ax = 16'(c); ay = 16'(a); az = 16'(b);
                end
            endcase
        end
        else if (pick < 85)
        begin
            ax = 16'($urandom);
            ay = 16'($urandom);
            az = 16'($urandom);
        end
        else if (pick < 95)
        begin
            ax = corner_value();
            ay = corner_value();
            az = corner_value();
        end
        else
        begin
            // lone x axis: pitch sees atan2 of zero by zero
            ax = $urandom_range(0, 1) ? 16'($urandom) : 16'sd0;
            ay = 16'sd0;
            az = 16'sd0;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            gx = 16'($urandom);
            gy = 16'($urandom);
        end
        else
        begin
            gx = 16'(int'($urandom_range(0, 4000)) - 2000);
            gy = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
        send_sample(ax, ay, az, gx, gy);
    endtask

    task automatic drain_pipeline();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(
        input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] weight,
        input logic [CFG_DATA_W-1:0] lo,   input logic [CFG_DATA_W-1:0] hi
    );
        cfg_we    <= 1'b1;
        cfg_index <= REG_GYRO_GAIN;
        cfg_data  <= gain;
        @(posedge clk);
        cfg_index <= REG_ACCEL_WEIGHT;
        cfg_data  <= weight;
        @(posedge clk);
        cfg_index <= REG_MAG_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_MAG_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        lim_low  = int'(lo);
        lim_high = int'(hi);
    endtask

    task automatic run_phase(
        input int count,
        input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] weight,
        input logic [CFG_DATA_W-1:0] lo,   input logic [CFG_DATA_W-1:0] hi,
        input bit calm_feed, input bit calm_drain
    );
        drain_pipeline();
        load_settings(gain, weight, lo, hi);
        feed_steady  = calm_feed;
        drain_steady = calm_drain;
        repeat (count) send_random();
    endtask

    // receiver back-pressure
    initial
    begin : result_drain
        int hold;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = idle_span(drain_steady);
            if (hold > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_ch.valid && sample_ch.ready)
                    || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_GYRO_GAIN;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.gyro_x  = '0;
        sample_ch.gyro_y  = '0;
        feed_steady       = 1'b0;
        drain_steady      = 1'b0;
        lim_low           = int'(MAG_LOW_RST);
        lim_high          = int'(MAG_HIGH_RST);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed items under the reset settings
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd100, -16'sd100);
        send_sample(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd8000, -16'sd8000, 16'sd0, 16'sd0);
        send_sample(-16'sd8000, -16'sd8000, -16'sd8000, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd12000, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0);
        // magnitude on and just inside each limit
        send_sample(16'sd0, 16'sd0, 16'sd8192, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd8193, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd16383, 16'sd16384, 16'sd0, 16'sd0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);

        // full gain and an overshooting weight: both angles run into saturation
        drain_pipeline();
        load_settings(17'h1ffff, 17'h1ffff, 17'd0, 17'h1ffff);
        for (i = 0; i < 3; i++)
            send_sample(16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000);
        for (i = 0; i < 3; i++)
            send_sample(16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7fff);
        send_sample(16'sd0, 16'sd16384, -16'sd16384, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sh7fff, -16'sd1, 16'sd1, 16'sd0, 16'sd0);

        run_phase(200, 17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)),
                  17'($urandom_range(0, 16384)), 17'($urandom_range(20000, 98304)),
                  1'b0, 1'b0);
        run_phase(150, CFG_DATA_W'(GYRO_GAIN_RST), CFG_DATA_W'(ACCEL_WEIGHT_RST),
                  CFG_DATA_W'(MAG_LOW_RST), CFG_DATA_W'(MAG_HIGH_RST),
                  1'b1, 1'b1);
        // equal limits: correction never applies
        run_phase(100, 17'd0, 17'd0, 17'd0, 17'd0, 1'b0, 1'b1);
        run_phase(150, 17'd65535, 17'd65536, 17'd0, 17'd98304, 1'b1, 1'b0);
        // reversed limits
        run_phase(100, 17'($urandom_range(0, 65535)), 17'd65536, 17'd98304, 17'd0,
                  1'b0, 1'b0);
        run_phase(150, 17'd1, 17'd1, 17'd0, 17'h1ffff, 1'b0, 1'b0);
        run_phase(100, 17'($urandom_range(0, 65535)), 17'($urandom_range(0, 65536)),
                  17'($urandom_range(0, 16384)), 17'($urandom_range(20000, 98304)),
                  1'b0, 1'b0);
        // sender holds off until every result is back, then carries on
        drain_pipeline();
        repeat (100) send_random();

        drain_pipeline();
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
